// ===== design/bfoc_pkg.sv =====
// Shared types and constants for the barometric first-order compensation block.
// Used by bfoc_ctrl, bfoc_dp and the top level; depends on nothing.
package bfoc_pkg;

  localparam int RawW   = 24;
  localparam int CoeffW = 16;
  localparam int TempW  = 19;
  localparam int PresW  = 22;
  localparam int DtW    = 26;
  localparam int MulBW  = 18;
  localparam int ProdW  = DtW + MulBW;
  localparam int OffW   = 36;
  localparam int SensW  = 35;
  localparam int AccW   = 60;
  localparam int QuotW  = 39;
  localparam int DiffW  = 40;
  localparam int CfgIdxW = 3;
  localparam int NumCoeff = 6;

  localparam int TempBase = 2000;

  localparam logic [CfgIdxW-1:0] REG_SENS_BASE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_BASE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TEMP_SLOPE  = 3'd5;

  localparam logic OP_TEMP  = 1'b0;
  localparam logic OP_PRESS = 1'b1;

  localparam int StepW = 4;
  localparam logic [StepW-1:0] ST_IDLE  = 4'd0;
  localparam logic [StepW-1:0] ST_TMUL  = 4'd1;
  localparam logic [StepW-1:0] ST_TFIN  = 4'd2;
  localparam logic [StepW-1:0] ST_POFF  = 4'd3;
  localparam logic [StepW-1:0] ST_PSENS = 4'd4;
  localparam logic [StepW-1:0] ST_PSCL  = 4'd5;
  localparam logic [StepW-1:0] ST_PLO   = 4'd6;
  localparam logic [StepW-1:0] ST_PHI   = 4'd7;
  localparam logic [StepW-1:0] ST_PSUM  = 4'd8;
  localparam logic [StepW-1:0] ST_PDIV  = 4'd9;
  localparam logic [StepW-1:0] ST_PSUB  = 4'd10;
  localparam logic [StepW-1:0] ST_PFIN  = 4'd11;
  localparam logic [StepW-1:0] ST_DONE  = 4'd12;

  typedef struct packed {
    logic [StepW-1:0] step;
    logic             load_in;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic is_press;
    logic raw_zero;
  } status_t;

endpackage

// ===== design/bfoc_ctrl.sv =====
// Sequencer for the compensation block: steps the shared multiplier schedule
// and owns the handshakes. Depends on bfoc_pkg.
module bfoc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  bfoc_pkg::status_t   status,
  output bfoc_pkg::cmd_t      cmd
);

  logic [bfoc_pkg::StepW-1:0] state;
  logic [bfoc_pkg::StepW-1:0] state_next;
  logic                       load_in;
  logic                       load_out;

  assign in_ready = (state == bfoc_pkg::ST_IDLE);
  assign load_in  = in_valid && in_ready;
  assign load_out = (state == bfoc_pkg::ST_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      bfoc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.is_press == bfoc_pkg::OP_TEMP) begin
            state_next = bfoc_pkg::ST_TMUL;
          end else if (status.raw_zero) begin
            state_next = bfoc_pkg::ST_DONE;
          end else begin
            state_next = bfoc_pkg::ST_POFF;
          end
        end
      end
      bfoc_pkg::ST_TMUL:  state_next = bfoc_pkg::ST_TFIN;
      bfoc_pkg::ST_TFIN:  state_next = bfoc_pkg::ST_DONE;
      bfoc_pkg::ST_POFF:  state_next = bfoc_pkg::ST_PSENS;
      bfoc_pkg::ST_PSENS: state_next = bfoc_pkg::ST_PSCL;
      bfoc_pkg::ST_PSCL:  state_next = bfoc_pkg::ST_PLO;
      bfoc_pkg::ST_PLO:   state_next = bfoc_pkg::ST_PHI;
      bfoc_pkg::ST_PHI:   state_next = bfoc_pkg::ST_PSUM;
      bfoc_pkg::ST_PSUM:  state_next = bfoc_pkg::ST_PDIV;
      bfoc_pkg::ST_PDIV:  state_next = bfoc_pkg::ST_PSUB;
      bfoc_pkg::ST_PSUB:  state_next = bfoc_pkg::ST_PFIN;
      bfoc_pkg::ST_PFIN:  state_next = bfoc_pkg::ST_DONE;
      bfoc_pkg::ST_DONE: begin
        if (load_out) begin
          state_next = bfoc_pkg::ST_IDLE;
        end
      end
      default: state_next = bfoc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfoc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cmd.step     = state;
  assign cmd.load_in  = load_in;
  assign cmd.load_out = load_out;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    load_in |=> !in_ready)
    else $error("accepted beat did not start a sequence");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("result load did not raise out_valid");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == bfoc_pkg::ST_DONE) && out_valid && !out_ready |=> state == bfoc_pkg::ST_DONE)
    else $error("sequence left done while output slot was busy");

  a_pfin_to_done: assert property (@(posedge clk) disable iff (rst)
    state == bfoc_pkg::ST_PFIN |=> state == bfoc_pkg::ST_DONE)
    else $error("pressure finish did not reach done");

endmodule

// ===== design/bfoc_dp.sv =====
// Datapath for the compensation block: calibration registers, dT/T/P state,
// one shared 26x18 signed multiplier and the result register. Depends on bfoc_pkg.
module bfoc_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bfoc_pkg::cmd_t                        cmd,
  output bfoc_pkg::status_t                     status,
  input  logic                                  op,
  input  logic [bfoc_pkg::RawW-1:0]             raw_value,
  input  logic                                  cfg_we,
  input  logic [bfoc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [bfoc_pkg::CoeffW-1:0]           cfg_data,
  output logic signed [bfoc_pkg::TempW-1:0]     temperature_out,
  output logic signed [bfoc_pkg::PresW-1:0]     pressure_out,
  output logic                                  pressure_updated
);

  logic [bfoc_pkg::CoeffW-1:0] c1;
  logic [bfoc_pkg::CoeffW-1:0] c2;
  logic [bfoc_pkg::CoeffW-1:0] c3;
  logic [bfoc_pkg::CoeffW-1:0] c4;
  logic [bfoc_pkg::CoeffW-1:0] c5;
  logic [bfoc_pkg::CoeffW-1:0] c6;

  logic [bfoc_pkg::RawW-1:0]          raw_q;
  logic signed [bfoc_pkg::DtW-1:0]    dt;
  logic signed [bfoc_pkg::TempW-1:0]  temp;
  logic signed [bfoc_pkg::PresW-1:0]  pres;
  logic                               upd;

  logic signed [bfoc_pkg::DtW-1:0]    mul_a;
  logic signed [bfoc_pkg::MulBW-1:0]  mul_b;
  logic signed [bfoc_pkg::ProdW-1:0]  mul_p;
  logic signed [bfoc_pkg::ProdW-1:0]  prod;

  logic signed [bfoc_pkg::OffW-1:0]   off;
  logic signed [bfoc_pkg::SensW-1:0]  sens;
  logic signed [bfoc_pkg::AccW-1:0]   acc;
  logic signed [bfoc_pkg::QuotW-1:0]  quot;
  logic signed [bfoc_pkg::DiffW-1:0]  diff;

  logic signed [bfoc_pkg::ProdW-1:0]  prod_b7;
  logic signed [bfoc_pkg::ProdW-1:0]  prod_b8;
  logic signed [bfoc_pkg::ProdW-1:0]  prod_b23;
  logic signed [bfoc_pkg::ProdW-1:0]  prod_s7;
  logic signed [bfoc_pkg::ProdW-1:0]  prod_s8;
  logic signed [bfoc_pkg::ProdW-1:0]  prod_s23;
  logic signed [bfoc_pkg::AccW-1:0]   acc_b21;
  logic signed [bfoc_pkg::AccW-1:0]   acc_s21;
  logic signed [bfoc_pkg::DiffW-1:0]  diff_b15;
  logic signed [bfoc_pkg::DiffW-1:0]  diff_s15;
  logic signed [bfoc_pkg::DtW-1:0]    dt_next;

  assign status.is_press = op;
  assign status.raw_zero = (raw_value == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
      c6 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfoc_pkg::REG_SENS_BASE:   c1 <= cfg_data;
        bfoc_pkg::REG_OFFSET_BASE: c2 <= cfg_data;
        bfoc_pkg::REG_SENS_TEMP:   c3 <= cfg_data;
        bfoc_pkg::REG_OFFSET_TEMP: c4 <= cfg_data;
        bfoc_pkg::REG_REF_TEMP:    c5 <= cfg_data;
        bfoc_pkg::REG_TEMP_SLOPE:  c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = dt;
    mul_b = $signed({2'b00, c6});
    case (cmd.step)
      bfoc_pkg::ST_POFF:  mul_b = $signed({2'b00, c4});
      bfoc_pkg::ST_PSENS: mul_b = $signed({2'b00, c3});
      bfoc_pkg::ST_PLO: begin
        mul_a = $signed({2'b00, raw_q});
        mul_b = $signed({1'b0, sens[16:0]});
      end
      bfoc_pkg::ST_PHI: begin
        mul_a = $signed({2'b00, raw_q});
        mul_b = sens[bfoc_pkg::SensW-1:17];
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // truncate toward zero: bias negative values before the arithmetic shift
  assign prod_b7  = prod + $signed({{(bfoc_pkg::ProdW-7){1'b0}}, {7{prod[bfoc_pkg::ProdW-1]}}});
  assign prod_b8  = prod + $signed({{(bfoc_pkg::ProdW-8){1'b0}}, {8{prod[bfoc_pkg::ProdW-1]}}});
  assign prod_b23 = prod + $signed({{(bfoc_pkg::ProdW-23){1'b0}},
                                    {23{prod[bfoc_pkg::ProdW-1]}}});
  assign prod_s7  = prod_b7 >>> 7;
  assign prod_s8  = prod_b8 >>> 8;
  assign prod_s23 = prod_b23 >>> 23;
  assign acc_b21  = acc + $signed({{(bfoc_pkg::AccW-21){1'b0}}, {21{acc[bfoc_pkg::AccW-1]}}});
  assign acc_s21  = acc_b21 >>> 21;
  assign diff_b15 = diff + $signed({{(bfoc_pkg::DiffW-15){1'b0}},
                                    {15{diff[bfoc_pkg::DiffW-1]}}});
  assign diff_s15 = diff_b15 >>> 15;
  assign dt_next  = $signed({2'b00, raw_value}) - $signed({2'b00, c5, 8'h00});

  always_ff @(posedge clk) begin
    if (rst) begin
      dt   <= '0;
      temp <= '0;
      pres <= '0;
    end else begin
      if (cmd.load_in && (op == bfoc_pkg::OP_TEMP)) begin
        dt <= dt_next;
      end
      if (cmd.step == bfoc_pkg::ST_TFIN) begin
        temp <= bfoc_pkg::TempW'(prod_s23) + bfoc_pkg::TempW'(bfoc_pkg::TempBase);
      end
      if (cmd.step == bfoc_pkg::ST_PFIN) begin
        pres <= bfoc_pkg::PresW'(diff_s15);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (cmd.load_in) begin
      raw_q <= raw_value;
      upd   <= 1'b0;
    end
    case (cmd.step)
      bfoc_pkg::ST_PSENS: off <= bfoc_pkg::OffW'(prod_s7) + $signed({4'b0000, c2, 16'h0000});
      bfoc_pkg::ST_PSCL:  sens <= bfoc_pkg::SensW'(prod_s8) + $signed({4'b0000, c1, 15'h0000});
      bfoc_pkg::ST_PHI:   acc <= bfoc_pkg::AccW'(prod);
      bfoc_pkg::ST_PSUM:  acc <= acc + (bfoc_pkg::AccW'(prod) <<< 17);
      bfoc_pkg::ST_PDIV:  quot <= bfoc_pkg::QuotW'(acc_s21);
      bfoc_pkg::ST_PSUB:  diff <= bfoc_pkg::DiffW'(quot) - bfoc_pkg::DiffW'(off);
      bfoc_pkg::ST_PFIN:  upd <= 1'b1;
      default: ;
    endcase
    if (cmd.load_out) begin
      temperature_out  <= temp;
      pressure_out     <= pres;
      pressure_updated <= upd;
    end
  end

endmodule

// ===== design/baro_first_order_compensation_top.sv =====
// Sequence: a temperature beat steps TMUL and TFIN, a nonzero pressure beat steps POFF,
// PSENS, PSCL, PLO, PHI, PSUM, PDIV, PSUB and PFIN, and a zero pressure beat goes to DONE;
// the next beat is taken the cycle after the previous result loads; a held result stalls it.
// The shared 26x18 multiplier, used four times per pressure beat, sets this schedule.
// Reset (synchronous): calibration words, dT, temperature and pressure clear to zero.
// Depends on bfoc_pkg, bfoc_ctrl and bfoc_dp.
module baro_first_order_compensation_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  op,
  input  logic [bfoc_pkg::RawW-1:0]             raw_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [bfoc_pkg::TempW-1:0]     temperature_out,
  output logic signed [bfoc_pkg::PresW-1:0]     pressure_out,
  output logic                                  pressure_updated,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bfoc_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [bfoc_pkg::CoeffW-1:0]           cfg_data
);

  bfoc_pkg::cmd_t    cmd;
  bfoc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  bfoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bfoc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .op               (op),
    .raw_value        (raw_value),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .temperature_out  (temperature_out),
    .pressure_out     (pressure_out),
    .pressure_updated (pressure_updated)
  );

endmodule

// ===== tb/baro_first_order_compensation_top_tb.sv =====
// Self-checking testbench for baro_first_order_compensation_top: sends tagged raw
// conversions under random gaps and stalls, predicts each compensated beat and checks it.
// Depends on bfoc_pkg and the baro_first_order_compensation_top RTL.
module baro_first_order_compensation_top_tb;

  localparam logic [bfoc_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bfoc_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int SettleCycles = 16;
  localparam int HoldCycles = 400;
  localparam int RandPhases = 10;
  localparam int PhaseReadings = 103;
  localparam int CycleLimit = 1000000;

  typedef struct {
    logic                       op;
    logic [bfoc_pkg::RawW-1:0]  raw;
  } reading_t;

  typedef struct {
    logic signed [bfoc_pkg::TempW-1:0] temp;
    logic signed [bfoc_pkg::PresW-1:0] pres;
    logic                              upd;
  } comp_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                op = bfoc_pkg::OP_TEMP;
  logic [bfoc_pkg::RawW-1:0]           raw_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [bfoc_pkg::TempW-1:0]   temperature_out;
  logic signed [bfoc_pkg::PresW-1:0]   pressure_out;
  logic                                pressure_updated;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bfoc_pkg::CfgIdxW-1:0]        cfg_index = '0;
  logic [bfoc_pkg::CoeffW-1:0]         cfg_data = '0;

  reading_t reading_q[$];
  comp_t    comp_q[$];
  longint   gain[bfoc_pkg::NumCoeff];
  longint   dt_acc;
  longint   temp_acc;
  longint   pres_acc;
  int       readings_queued;
  int       results_seen;
  int       err_cnt;
  int       cycles;
  int       in_gap;
  int       out_stall;
  int       hold_cnt;
  bit       calm;
  bit       hold_req;
  bit       hold_ack;
  bit       rx_hold;

  baro_first_order_compensation_top i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .op               (op),
    .raw_value        (raw_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .temperature_out  (temperature_out),
    .pressure_out     (pressure_out),
    .pressure_updated (pressure_updated),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [bfoc_pkg::CoeffW-1:0] pick_coeff();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return bfoc_pkg::CoeffW'($urandom());
  endfunction

  function automatic reading_t pick_reading();
    reading_t rd;
    int r;
    rd.op = $urandom_range(0, 1) ? bfoc_pkg::OP_PRESS : bfoc_pkg::OP_TEMP;
    r = $urandom_range(0, 19);
    if (r == 0) rd.raw = '0;
    else if (r == 1) rd.raw = '1;
    else if (r < 5 && rd.op == bfoc_pkg::OP_TEMP)
      rd.raw = bfoc_pkg::RawW'(gain[bfoc_pkg::REG_REF_TEMP] * 256
                               + $urandom_range(0, 511) - 256);
    else rd.raw = bfoc_pkg::RawW'($urandom());
    return rd;
  endfunction

  function automatic comp_t compensate(reading_t rd);
    longint raw;
    longint off;
    longint sens;
    comp_t  res;
    raw = rd.raw;
    res.upd = 1'b0;
    if (rd.op == bfoc_pkg::OP_TEMP) begin
      dt_acc = raw - gain[bfoc_pkg::REG_REF_TEMP] * 256;
      temp_acc = bfoc_pkg::TempBase
                 + (dt_acc * gain[bfoc_pkg::REG_TEMP_SLOPE]) / 8388608;
    end else begin
      off = gain[bfoc_pkg::REG_OFFSET_BASE] * 65536
            + (gain[bfoc_pkg::REG_OFFSET_TEMP] * dt_acc) / 128;
      sens = gain[bfoc_pkg::REG_SENS_BASE] * 32768
             + (gain[bfoc_pkg::REG_SENS_TEMP] * dt_acc) / 256;
      if (raw != 0) begin
        pres_acc = ((raw * sens) / 2097152 - off) / 32768;
        res.upd = 1'b1;
      end
    end
    res.temp = temp_acc[bfoc_pkg::TempW-1:0];
    res.pres = pres_acc[bfoc_pkg::PresW-1:0];
    return res;
  endfunction

  always @(posedge clk) begin : drive_p
    reading_t nxt;
    reading_t cur;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        cur.op = op;
        cur.raw = raw_value;
        comp_q.push_back(compensate(cur));
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (reading_q.size() != 0) begin
          nxt = reading_q.pop_front();
          op <= nxt.op;
          raw_value <= nxt.raw;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_p
    comp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (comp_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected beat, temperature %0d pressure %0d updated %0d",
                   $time, temperature_out, pressure_out, pressure_updated);
        end else begin
          want = comp_q.pop_front();
          if (temperature_out !== want.temp) begin
            err_cnt++;
            $display("%0t: temperature_out expected %0d got %0d",
                     $time, want.temp, temperature_out);
          end
          if (pressure_out !== want.pres) begin
            err_cnt++;
            $display("%0t: pressure_out expected %0d got %0d",
                     $time, want.pres, pressure_out);
          end
          if (pressure_updated !== want.upd) begin
            err_cnt++;
            $display("%0t: pressure_updated expected %0d got %0d",
                     $time, want.upd, pressure_updated);
          end
        end
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (out_stall != 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  // hold the result side off for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      rx_hold <= 1'b0;
      hold_cnt <= 0;
      hold_ack <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      rx_hold <= (hold_cnt != 1);
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_cnt <= HoldCycles;
      rx_hold <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_coeff(input logic [bfoc_pkg::CfgIdxW-1:0] idx,
                             input logic [bfoc_pkg::CoeffW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < bfoc_pkg::NumCoeff) gain[idx] = val;
  endtask

  task automatic queue_reading(input logic opv, input logic [bfoc_pkg::RawW-1:0] raw);
    reading_t rd;
    rd.op = opv;
    rd.raw = raw;
    reading_q.push_back(rd);
    readings_queued++;
  endtask

  task automatic drain();
    while (results_seen < readings_queued) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < bfoc_pkg::NumCoeff; i++) gain[i] = 0;
    dt_acc = 0;
    temp_acc = 0;
    pres_acc = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_coeff(bfoc_pkg::REG_SENS_BASE, 16'd40127);
    write_coeff(bfoc_pkg::REG_OFFSET_BASE, 16'd36924);
    write_coeff(bfoc_pkg::REG_SENS_TEMP, 16'd23317);
    write_coeff(bfoc_pkg::REG_OFFSET_TEMP, 16'd23282);
    write_coeff(bfoc_pkg::REG_REF_TEMP, 16'd33464);
    write_coeff(bfoc_pkg::REG_TEMP_SLOPE, 16'd28312);
    write_coeff(REG_SPARE_LO, 16'h0000);
    write_coeff(REG_SPARE_HI, 16'hFFFF);
    cfg_valid <= 1'b0;
    // pressure before any temperature beat, then zero and extreme readings
    queue_reading(bfoc_pkg::OP_PRESS, '1);
    queue_reading(bfoc_pkg::OP_PRESS, '0);
    queue_reading(bfoc_pkg::OP_PRESS, 24'd1);
    queue_reading(bfoc_pkg::OP_TEMP, '0);
    queue_reading(bfoc_pkg::OP_PRESS, '1);
    queue_reading(bfoc_pkg::OP_PRESS, '0);
    queue_reading(bfoc_pkg::OP_TEMP, '1);
    queue_reading(bfoc_pkg::OP_PRESS, '1);
    queue_reading(bfoc_pkg::OP_PRESS, 24'd1);
    queue_reading(bfoc_pkg::OP_TEMP, bfoc_pkg::RawW'(gain[bfoc_pkg::REG_REF_TEMP] * 256));
    queue_reading(bfoc_pkg::OP_PRESS, 24'h800000);
    queue_reading(bfoc_pkg::OP_TEMP, 24'h555555);
    queue_reading(bfoc_pkg::OP_PRESS, 24'hAAAAAA);
    drain();

    for (int i = 0; i < bfoc_pkg::NumCoeff; i++)
      write_coeff(i[bfoc_pkg::CfgIdxW-1:0], '1);
    cfg_valid <= 1'b0;
    queue_reading(bfoc_pkg::OP_TEMP, '0);
    queue_reading(bfoc_pkg::OP_PRESS, '1);
    queue_reading(bfoc_pkg::OP_PRESS, 24'd1);
    queue_reading(bfoc_pkg::OP_PRESS, '0);
    queue_reading(bfoc_pkg::OP_TEMP, '1);
    queue_reading(bfoc_pkg::OP_PRESS, '1);
    queue_reading(bfoc_pkg::OP_PRESS, 24'd1);
    drain();

    for (int i = 0; i < bfoc_pkg::NumCoeff; i++)
      write_coeff(i[bfoc_pkg::CfgIdxW-1:0], '0);
    write_coeff(REG_SPARE_HI, '1);
    cfg_valid <= 1'b0;
    queue_reading(bfoc_pkg::OP_TEMP, '1);
    queue_reading(bfoc_pkg::OP_PRESS, '1);
    queue_reading(bfoc_pkg::OP_PRESS, '0);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      for (int i = 0; i < bfoc_pkg::NumCoeff; i++)
        write_coeff(i[bfoc_pkg::CfgIdxW-1:0], pick_coeff());
      if ($urandom_range(0, 2) == 0)
        write_coeff($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                    bfoc_pkg::CoeffW'($urandom()));
      cfg_valid <= 1'b0;
      calm = (ph == 2 || ph == 6);
      for (int i = 0; i < PhaseReadings; i++) begin
        reading_t rd;
        rd = pick_reading();
        queue_reading(rd.op, rd.raw);
      end
      if (ph == 4) hold_req = ~hold_req;
      drain();
    end

    if (comp_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected beats never arrived", $time, comp_q.size());
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bfoc_pkg.sv
design/bfoc_ctrl.sv
design/bfoc_dp.sv
design/baro_first_order_compensation_top.sv
tb/baro_first_order_compensation_top_tb.sv
